// File: design/aft_pkg.sv
// shared types and constants for the 3x4 affine transform unit
// no dependencies; imported by every module of the block
package aft_pkg;

    // request kind carried in the input tuser field
    typedef enum logic [1:0] {
        REQ_LOAD       = 2'd0,
        REQ_FORWARD    = 2'd1,
        REQ_INVERSE    = 2'd2,
        REQ_INV_ROTATE = 2'd3
    } req_t;

    localparam int MAT_ROWS    = 3;
    localparam int MAT_COLS    = 4;
    localparam int MAT_ENTRIES = MAT_ROWS * MAT_COLS;
    localparam int TRANS_COL   = 3;
    localparam int LANES       = 3;
    localparam int IDX_W       = 4;
    localparam int REQ_W       = 2;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic out;
    } stage_en_t;

endpackage

// File: design/aft_front.sv
// front end: input word register, matrix store and operand selection per mode
// depends on aft_pkg
module aft_front
    import aft_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  stage_en_t                    en,
    input  logic                         load_en,
    input  logic [IDX_W-1:0]             load_idx,
    input  logic signed [DATA_WIDTH-1:0] load_value,
    input  req_t                         in_req,
    input  logic signed [DATA_WIDTH-1:0] in_vec  [LANES],
    output logic signed [DATA_WIDTH:0]   vop     [LANES],
    output logic signed [DATA_WIDTH-1:0] coef    [LANES][LANES],
    output logic signed [DATA_WIDTH-1:0] tadd    [LANES]
);

    localparam int VW = DATA_WIDTH + 1;

    logic signed [DATA_WIDTH-1:0] mat_reg  [MAT_ENTRIES];
    req_t                         req_reg;
    logic signed [DATA_WIDTH-1:0] vec_reg  [LANES];

    logic signed [VW-1:0]         vop_reg  [LANES];
    logic signed [VW-1:0]         vop_next [LANES];
    logic signed [DATA_WIDTH-1:0] coef_reg  [LANES][LANES];
    logic signed [DATA_WIDTH-1:0] coef_next [LANES][LANES];
    logic signed [DATA_WIDTH-1:0] tadd_reg  [LANES];
    logic signed [DATA_WIDTH-1:0] tadd_next [LANES];

    // matrix store, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < MAT_ENTRIES; e++) begin
                mat_reg[e] <= '0;
            end
        end else if (load_en && (load_idx < IDX_W'(MAT_ENTRIES))) begin
            mat_reg[load_idx] <= load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            req_reg <= in_req;
            vec_reg <= in_vec;
        end
    end

    // operands: forward uses rows of R, the inverse modes use columns
    always_comb begin
        unique case (req_reg)
            REQ_FORWARD: begin
                for (int i = 0; i < LANES; i++) begin
                    vop_next[i]  = VW'(vec_reg[i]);
                    tadd_next[i] = mat_reg[i*MAT_COLS+TRANS_COL];
                    for (int k = 0; k < LANES; k++) begin
                        coef_next[i][k] = mat_reg[i*MAT_COLS+k];
                    end
                end
            end
            REQ_INVERSE: begin
                for (int i = 0; i < LANES; i++) begin
                    vop_next[i]  = VW'(vec_reg[i]) - VW'(mat_reg[i*MAT_COLS+TRANS_COL]);
                    tadd_next[i] = '0;
                    for (int k = 0; k < LANES; k++) begin
                        coef_next[i][k] = mat_reg[k*MAT_COLS+i];
                    end
                end
            end
            REQ_LOAD, REQ_INV_ROTATE: begin
                for (int i = 0; i < LANES; i++) begin
                    vop_next[i]  = VW'(vec_reg[i]);
                    tadd_next[i] = '0;
                    for (int k = 0; k < LANES; k++) begin
                        coef_next[i][k] = mat_reg[k*MAT_COLS+i];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            vop_reg  <= vop_next;
            coef_reg <= coef_next;
            tadd_reg <= tadd_next;
        end
    end

    assign vop  = vop_reg;
    assign coef = coef_reg;
    assign tadd = tadd_reg;

endmodule

// File: design/aft_lane.sv
// one output component: three products, sum with translation, shift and saturate
// depends on aft_pkg
module aft_lane
    import aft_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  stage_en_t                    en,
    input  logic signed [DATA_WIDTH:0]   vop  [LANES],
    input  logic signed [DATA_WIDTH-1:0] coef [LANES],
    input  logic signed [DATA_WIDTH-1:0] tadd,
    output logic signed [DATA_WIDTH-1:0] sat_value,
    output logic                         sat_flag
);

    localparam int VW = DATA_WIDTH + 1;
    localparam int PW = VW + DATA_WIDTH;
    localparam int SW = PW + 2;

    logic signed [PW-1:0]         prod_reg [LANES];
    logic signed [DATA_WIDTH-1:0] tadd_reg;
    logic signed [SW-1:0]         sum_reg;
    logic signed [SW-1:0]         sum_next;
    logic signed [SW-1:0]         shifted;
    logic                         all_ones;
    logic                         all_zeros;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            for (int k = 0; k < LANES; k++) begin
                prod_reg[k] <= PW'(vop[k]) * PW'(coef[k]);
            end
            tadd_reg <= tadd;
        end
    end

    // translation enters scaled to the product's fraction
    always_comb begin
        sum_next = (SW'(tadd_reg) <<< FRAC_BITS);
        for (int k = 0; k < LANES; k++) begin
            sum_next = sum_next + SW'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            sum_reg <= sum_next;
        end
    end

    // floor shift, then clamp when the upper bits are not a sign extension
    assign shifted   = sum_reg >>> FRAC_BITS;
    assign all_ones  = &shifted[SW-1:DATA_WIDTH-1];
    assign all_zeros = ~(|shifted[SW-1:DATA_WIDTH-1]);
    assign sat_flag  = ~(all_ones | all_zeros);

    always_comb begin
        if (sat_flag) begin
            sat_value = {shifted[SW-1], {(DATA_WIDTH-1){~shifted[SW-1]}}};
        end else begin
            sat_value = shifted[DATA_WIDTH-1:0];
        end
    end

endmodule

// File: design/aft_merge.sv
// merge stage: packs the lane results and folds their clamp flags into one
// depends on aft_pkg
module aft_merge
    import aft_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int OUT_W      = 96
) (
    input  logic                         aclk,
    input  stage_en_t                    en,
    input  logic signed [DATA_WIDTH-1:0] lane_value [LANES],
    input  logic [LANES-1:0]             lane_flag,
    output logic [OUT_W-1:0]             out_data,
    output logic                         out_ovf
);

    logic [OUT_W-1:0] data_reg;
    logic [OUT_W-1:0] data_next;
    logic             ovf_reg;

    always_comb begin
        data_next = '0;
        for (int k = 0; k < LANES; k++) begin
            data_next[k*DATA_WIDTH +: DATA_WIDTH] = lane_value[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.out) begin
            data_reg <= data_next;
            ovf_reg  <= |lane_flag;
        end
    end

    assign out_data = data_reg;
    assign out_ovf  = ovf_reg;

endmodule

// File: design/affine_transform_3x4.sv
// 3x4 affine transform unit, top level: stream ports, pipeline control, lanes
// depends on aft_pkg, aft_front, aft_lane and aft_merge
//
// Holds a 3x4 signed fixed-point matrix (rotation R in columns 0..2,
// translation t in column 3). A load word (tuser = 0) writes one entry,
// row*4 + column, and gives no result; indexes above eleven are dropped.
// Transform words give one result each: forward R*v + t, inverse
// R^T*(v - t), inverse-rotate R^T*v. Each output component is the full
// width sum shifted right by FRAC_BITS (rounding toward minus infinity)
// and saturated to DATA_WIDTH bits; m_axis_tuser flags any clamp.
// The block takes one word per cycle: the three lanes each run a fully
// pipelined multiply/add datapath, so throughput is set only by the
// output handshake. A result passes the input, operand, product, sum and
// output registers in turn; a load takes effect for the very next word.
// The matrix is cleared by reset.
module affine_transform_3x4
    import aft_pkg::*;
#(
    parameter  int DATA_WIDTH = 32,
    parameter  int FRAC_BITS  = 16,
    localparam int S_TDATA_W  = ((IDX_W + 4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((LANES * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // entry_index, entry_value, vec_x, vec_y, vec_z, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_x, out_y, out_z, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // overflow
    output logic [0:0]           m_axis_tuser
);

    localparam int VAL_LSB = IDX_W;
    localparam int VEC_LSB = IDX_W + DATA_WIDTH;

    // unpacked input fields
    req_t                         in_req;
    logic [IDX_W-1:0]             in_idx;
    logic signed [DATA_WIDTH-1:0] in_value;
    logic signed [DATA_WIDTH-1:0] in_vec [LANES];

    // stage occupancy and ready chain
    logic      v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic      rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic      accept;
    logic      accept_xf;
    stage_en_t en;

    // datapath between units
    logic signed [DATA_WIDTH:0]   vop  [LANES];
    logic signed [DATA_WIDTH-1:0] coef [LANES][LANES];
    logic signed [DATA_WIDTH-1:0] tadd [LANES];
    logic signed [DATA_WIDTH-1:0] lane_value [LANES];
    logic [LANES-1:0]             lane_flag;
    logic                         out_ovf;

    assign in_req   = req_t'(s_axis_tuser);
    assign in_idx   = s_axis_tdata[IDX_W-1:0];
    assign in_value = s_axis_tdata[VAL_LSB +: DATA_WIDTH];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            in_vec[k] = s_axis_tdata[VEC_LSB + k*DATA_WIDTH +: DATA_WIDTH];
        end
    end

    // a stage can load when empty or when its word moves on this cycle
    assign rdy_out = !vo_reg || m_axis_tready;
    assign rdy4    = !v4_reg || rdy_out;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    // load words stop at the matrix store and never enter the pipeline
    assign accept_xf     = accept && (in_req != REQ_LOAD);

    assign en.s1  = accept_xf;
    assign en.s2  = rdy2 && v1_reg;
    assign en.s3  = rdy3 && v2_reg;
    assign en.s4  = rdy4 && v3_reg;
    assign en.out = rdy_out && v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= accept_xf;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy_out) begin
                vo_reg <= v4_reg;
            end
        end
    end

    // matrix store and operand selection; the matrix is sampled when a word
    // leaves stage one, so loads behind it never reach back
    aft_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .load_en    (accept && (in_req == REQ_LOAD)),
        .load_idx   (in_idx),
        .load_value (in_value),
        .in_req     (in_req),
        .in_vec     (in_vec),
        .vop        (vop),
        .coef       (coef),
        .tadd       (tadd)
    );

    // one lane per output component
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        aft_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .en        (en),
            .vop       (vop),
            .coef      (coef[g]),
            .tadd      (tadd[g]),
            .sat_value (lane_value[g]),
            .sat_flag  (lane_flag[g])
        );
    end

    // output register, also the skid point toward the result side
    aft_merge #(
        .DATA_WIDTH (DATA_WIDTH),
        .OUT_W      (M_TDATA_W)
    ) u_merge (
        .aclk       (aclk),
        .en         (en),
        .lane_value (lane_value),
        .lane_flag  (lane_flag),
        .out_data   (m_axis_tdata),
        .out_ovf    (out_ovf)
    );

    assign m_axis_tvalid   = vo_reg;
    assign m_axis_tuser[0] = out_ovf;

endmodule
